[rtl/kvpt_pkg.sv]
// kvpt_pkg: shared types, character codes and helpers for the key/value tokenizer
// no dependencies; used by the interfaces, kvpt_classify and the top level
`timescale 1ns / 1ps

package kvpt_pkg;

  localparam int CHAR_W         = 8;
  localparam int ROLE_W         = 3;
  localparam int NEST_W         = 8;
  localparam int DEPTH_BITS_DEF = 8;

  localparam logic [NEST_W-1:0] NEST_MAX = {NEST_W{1'b1}};

  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_EQUAL  = 8'h3D;

  typedef enum logic [ROLE_W-1:0] {
    ROLE_SEP    = 3'd0,
    ROLE_KEY    = 3'd1,
    ROLE_KDELIM = 3'd2,
    ROLE_VALUE  = 3'd3,
    ROLE_PEND   = 3'd4,
    ROLE_TERM   = 3'd5
  } role_e;

  typedef enum logic [2:0] {
    PH_SKIP  = 3'b001,
    PH_KEY   = 3'b010,
    PH_VALUE = 3'b100
  } phase_e;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    role_e             role;
    logic              pair_end;
    logic              value_mode;
    logic [NEST_W-1:0] nest_depth;
  } result_t;

  function automatic logic is_sep(input logic [CHAR_W-1:0] c);
    is_sep = (c == CH_COMMA) || (c == CH_SPACE) || (c == CH_TAB) ||
             (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

[rtl/kvpt_in_if.sv]
// kvpt_in_if: input byte channel, valid/ready with one byte of payload
// depends on kvpt_pkg
`timescale 1ns / 1ps

interface kvpt_in_if
  import kvpt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

[rtl/kvpt_out_if.sv]
// kvpt_out_if: classified byte channel, valid/ready with the tagged word
// depends on kvpt_pkg
`timescale 1ns / 1ps

interface kvpt_out_if
  import kvpt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic [ROLE_W-1:0] role;
  logic              pair_end;
  logic              value_mode;
  logic [NEST_W-1:0] nest_depth;

  modport source (output valid, output char_out, output role, output pair_end,
                  output value_mode, output nest_depth, input ready);
  modport sink   (input valid, input char_out, input role, input pair_end,
                  input value_mode, input nest_depth, output ready);
endinterface

[rtl/kvpt_classify.sv]
// kvpt_classify: tokenizer state (phase, value mode, nesting depth) and the
// per-byte classification logic; depends on kvpt_pkg
`timescale 1ns / 1ps

module kvpt_classify
  import kvpt_pkg::*;
#(
  parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [CHAR_W-1:0] char_i,
  output result_t           result_o
);

  localparam logic [DEPTH_BITS-1:0] LevelMax = {DEPTH_BITS{1'b1}};
  localparam int ExtW = (DEPTH_BITS > NEST_W) ? DEPTH_BITS : NEST_W;

  phase_e                phase_q, phase_d;
  logic                  close_q, close_d;
  logic [DEPTH_BITS-1:0] level_q, level_d;
  logic                  has_val_q, has_val_d;

  role_e           role;
  logic            pend;
  logic            sep;
  logic            vstart;
  logic            ends;
  logic [ExtW-1:0] level_ext;

  assign sep    = is_sep(char_i);
  assign vstart = (char_i == CH_COLON) || (char_i == CH_EQUAL) ||
                  (char_i == CH_LPAREN);

  always_comb begin
    phase_d   = phase_q;
    close_d   = close_q;
    level_d   = level_q;
    has_val_d = has_val_q;
    role      = ROLE_SEP;
    pend      = 1'b0;
    ends      = close_q ? (char_i == CH_RPAREN) : sep;

    case (phase_q)
      PH_KEY: begin
        if (char_i == CH_NUL) begin
          role = ROLE_TERM;
          pend = 1'b1;
        end else if (vstart) begin
          role      = ROLE_KDELIM;
          phase_d   = PH_VALUE;
          close_d   = (char_i == CH_LPAREN);
          has_val_d = 1'b1;
          level_d   = '0;
        end else if (sep) begin
          role = ROLE_PEND;
          pend = 1'b1;
        end else begin
          role = ROLE_KEY;
        end
      end
      PH_VALUE: begin
        if (char_i == CH_NUL) begin
          role = ROLE_TERM;
          pend = 1'b1;
        end else if (level_q == '0) begin
          if (ends) begin
            role = ROLE_PEND;
            pend = 1'b1;
          end else begin
            role = ROLE_VALUE;
            if (char_i == CH_LPAREN) level_d = DEPTH_BITS'(1);
          end
        end else begin
          role = ROLE_VALUE;
          if (char_i == CH_LPAREN) begin
            if (level_q != LevelMax) level_d = level_q + DEPTH_BITS'(1);
          end else if (char_i == CH_RPAREN) begin
            level_d = level_q - DEPTH_BITS'(1);
          end
        end
      end
      default: begin
        // skipping separators; unused codes land here as well
        phase_d = PH_SKIP;
        if (char_i == CH_NUL) begin
          role = ROLE_TERM;
        end else if (sep) begin
          role = ROLE_SEP;
        end else if (vstart) begin
          // empty key, value follows
          role      = ROLE_KDELIM;
          phase_d   = PH_VALUE;
          close_d   = (char_i == CH_LPAREN);
          has_val_d = 1'b1;
          level_d   = '0;
        end else begin
          role      = ROLE_KEY;
          phase_d   = PH_KEY;
          has_val_d = 1'b0;
        end
      end
    endcase

    result_o.value_mode = has_val_d;

    if (pend || (char_i == CH_NUL)) begin
      phase_d   = PH_SKIP;
      close_d   = 1'b0;
      level_d   = '0;
      has_val_d = 1'b0;
    end

    level_ext           = ExtW'(level_d);
    result_o.char_out   = char_i;
    result_o.role       = role;
    result_o.pair_end   = pend;
    result_o.nest_depth = (level_ext > ExtW'(NEST_MAX)) ? NEST_MAX : level_ext[NEST_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SKIP;
      close_q   <= 1'b0;
      level_q   <= '0;
      has_val_q <= 1'b0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      close_q   <= close_d;
      level_q   <= level_d;
      has_val_q <= has_val_d;
    end
  end

  a_pend_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && result_o.pair_end |=> phase_q == PH_SKIP && level_q == '0 && !has_val_q)
    else $error("pair end did not clear the tokenizer state");

  a_term_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && char_i == CH_NUL |=> phase_q == PH_SKIP && !close_q)
    else $error("terminator did not return to the skip phase");

  a_level_in_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q != '0 |-> phase_q == PH_VALUE)
    else $error("nesting depth held outside a value");

  a_key_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_KEY |-> !has_val_q && !close_q)
    else $error("value mode set while still in a key");

endmodule

[rtl/key_value_pair_tokenizer_core.sv]
// key_value_pair_tokenizer_core: top level, classification plus a two-word
// output buffer; depends on kvpt_pkg, kvpt_in_if, kvpt_out_if, kvpt_classify
`timescale 1ns / 1ps

// Tags each byte of a zero-terminated string with its role (separator, key
// byte, key delimiter, value byte, pair-ending delimiter, terminator) along
// with pair-end, value-mode and nesting-depth flags. One byte is accepted
// per cycle while input ready is high; its tagged word is registered into
// the output register, or into the buffer word while the output stalls. The
// rate rests on kvpt_classify updating its phase and depth registers with
// each accepted byte. The two-word buffer lets the input take one more byte
// after the output stalls; input ready drops only when both words are held.
module key_value_pair_tokenizer_core
  import kvpt_pkg::*;
#(
  parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  kvpt_in_if.sink    in_i,
  kvpt_out_if.source out_o
);

  result_t res;
  result_t out_data_q, skid_data_q;
  logic    out_valid_q, skid_valid_q;
  logic    accept;
  logic    pop;

  assign in_i.ready = !skid_valid_q;
  assign accept     = in_i.valid && !skid_valid_q;
  assign pop        = out_valid_q && out_o.ready;

  kvpt_classify #(
    .DEPTH_BITS(DEPTH_BITS)
  ) u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .char_i  (in_i.char_in),
    .result_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop || !out_valid_q) begin
      if (skid_valid_q) out_data_q <= skid_data_q;
      else if (accept)  out_data_q <= res;
    end else if (accept) begin
      skid_data_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.char_out   = out_data_q.char_out;
  assign out_o.role       = out_data_q.role;
  assign out_o.pair_end   = out_data_q.pair_end;
  assign out_o.value_mode = out_data_q.value_mode;
  assign out_o.nest_depth = out_data_q.nest_depth;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("buffered word without a word in the output register");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready && accept |=> skid_valid_q && out_valid_q)
    else $error("word accepted under stall was not buffered");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && out_o.ready |=> !skid_valid_q && out_valid_q)
    else $error("buffered word not moved forward after a pop");

endmodule

[tb/key_value_pair_tokenizer_core_test.sv]
// key_value_pair_tokenizer_core_test: streams byte strings through the tokenizer and checks
// every tagged word against a cycle-free model of the byte roles kept in this file
// depends on kvpt_pkg, kvpt_in_if, kvpt_out_if and key_value_pair_tokenizer_core
`timescale 1ns / 1ps

module key_value_pair_tokenizer_core_test;
  import kvpt_pkg::*;

  localparam int DEPTH_BITS  = DEPTH_BITS_DEF;
  localparam int LEVEL_MAX   = (1 << DEPTH_BITS) - 1;
  localparam int RANDOM_ITEMS = 900;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  kvpt_in_if  in_if ();
  kvpt_out_if out_if ();

  key_value_pair_tokenizer_core #(
    .DEPTH_BITS(DEPTH_BITS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #5 clk = ~clk;

  logic [CHAR_W-1:0] pending_chars [$];
  result_t           expected_words [$];
  int                error_count = 0;
  int                cycle_count = 0;

  // tokenizer state as the block should hold it
  phase_e                tok_phase = PH_SKIP;
  logic                  tok_close_paren = 1'b0;
  logic [DEPTH_BITS-1:0] tok_level = '0;
  logic                  tok_has_value = 1'b0;

  // directed strings: terminator alone, extreme key bytes, empty keys, hidden
  // separators, paren value, terminator inside an open group, key cut by terminator
  logic [CHAR_W-1:0] directed_chars [26] = '{
    CH_NUL,
    8'h01, 8'hFF, CH_COMMA,
    CH_COLON, "v", CH_TAB,
    CH_EQUAL, CH_LPAREN, "a", CH_SPACE, "b", CH_RPAREN, CH_CR,
    "k", CH_LPAREN, "x", CH_RPAREN, CH_LF,
    CH_LPAREN, CH_LPAREN, CH_LPAREN, CH_NUL,
    CH_SPACE, "q", CH_NUL
  };

  function automatic logic is_separator(input logic [CHAR_W-1:0] c);
    return c == CH_COMMA || c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  // a : = or ( opens the value of the current pair
  function automatic logic enter_value(input logic [CHAR_W-1:0] c);
    if (c == CH_COLON || c == CH_EQUAL) begin
      tok_close_paren = 1'b0;
    end else if (c == CH_LPAREN) begin
      tok_close_paren = 1'b1;
    end else begin
      return 1'b0;
    end
    tok_phase = PH_VALUE;
    tok_has_value = 1'b1;
    tok_level = '0;
    return 1'b1;
  endfunction

  function automatic result_t classify_byte(input logic [CHAR_W-1:0] c);
    result_t word;
    role_e   role;
    logic    pend;
    logic    ends;
    pend = 1'b0;
    role = ROLE_SEP;
    case (tok_phase)
      PH_KEY: begin
        if (c == CH_NUL) begin
          role = ROLE_TERM;
          pend = 1'b1;
        end else if (enter_value(c)) begin
          role = ROLE_KDELIM;
        end else if (is_separator(c)) begin
          role = ROLE_PEND;
          pend = 1'b1;
        end else begin
          role = ROLE_KEY;
        end
      end
      PH_VALUE: begin
        if (c == CH_NUL) begin
          role = ROLE_TERM;
          pend = 1'b1;
        end else if (tok_level == 0) begin
          ends = tok_close_paren ? (c == CH_RPAREN) : is_separator(c);
          if (ends) begin
            role = ROLE_PEND;
            pend = 1'b1;
          end else begin
            role = ROLE_VALUE;
            if (c == CH_LPAREN) tok_level = DEPTH_BITS'(1);
          end
        end else begin
          role = ROLE_VALUE;
          if (c == CH_LPAREN) begin
            if (int'(tok_level) < LEVEL_MAX) tok_level = tok_level + 1'b1;
          end else if (c == CH_RPAREN) begin
            tok_level = tok_level - 1'b1;
          end
        end
      end
      default: begin
        tok_phase = PH_SKIP;
        if (c == CH_NUL) begin
          role = ROLE_TERM;
        end else if (is_separator(c)) begin
          role = ROLE_SEP;
        end else if (enter_value(c)) begin
          role = ROLE_KDELIM;
        end else begin
          tok_phase = PH_KEY;
          tok_has_value = 1'b0;
          role = ROLE_KEY;
        end
      end
    endcase
    word.char_out = c;
    word.role = role;
    word.pair_end = pend;
    word.value_mode = tok_has_value;
    if (pend || c == CH_NUL) begin
      tok_phase = PH_SKIP;
      tok_close_paren = 1'b0;
      tok_level = '0;
      tok_has_value = 1'b0;
    end
    word.nest_depth = (int'(tok_level) > int'(NEST_MAX)) ? NEST_MAX : NEST_W'(tok_level);
    return word;
  endfunction

  function automatic logic [CHAR_W-1:0] sep_char();
    case ($urandom_range(0, 4))
      0: return CH_COMMA;
      1: return CH_SPACE;
      2: return CH_TAB;
      3: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] key_char();
    case ($urandom_range(0, 9))
      0: return CHAR_W'($urandom_range(8'h80, 8'hFF));
      1: return CH_RPAREN;
      2: return CHAR_W'($urandom_range("0", "9"));
      default: return CHAR_W'($urandom_range("a", "z"));
    endcase
  endfunction

  // never a separator or a parenthesis, so it cannot end a value
  function automatic logic [CHAR_W-1:0] value_char();
    case ($urandom_range(0, 9))
      0: return CHAR_W'($urandom_range(8'h80, 8'hFF));
      1: return CH_COLON;
      2: return CH_EQUAL;
      3: return CHAR_W'($urandom_range(8'h01, 8'h08));
      default: return CHAR_W'($urandom_range("a", "z"));
    endcase
  endfunction

  // mostly short gaps, a few long ones, none while calm
  function automatic int idle_length(input logic calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string field, input int unsigned want_v,
                                 input int unsigned got_v);
    $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want_v, got_v);
    error_count++;
  endtask

  // input driver
  int   send_gap = 0;
  logic send_calm = 1'b0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        expected_words.push_back(classify_byte(in_if.char_in));
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_if.valid <= 1'b0;
        end else if (pending_chars.size() > 0) begin
          in_if.valid <= 1'b1;
          in_if.char_in <= pending_chars.pop_front();
          if ($urandom_range(0, 99) == 0) send_calm = !send_calm;
          send_gap <= idle_length(send_calm);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and ready stalls
  int   stall_left = 0;
  logic recv_calm = 1'b0;

  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, expected none actual %0h", $time, out_if.char_out);
          error_count++;
        end else begin
          want = expected_words.pop_front();
          if (out_if.char_out !== want.char_out)
            report_mismatch("char_out", want.char_out, out_if.char_out);
          if (out_if.role !== want.role)
            report_mismatch("role", want.role, out_if.role);
          if (out_if.pair_end !== want.pair_end)
            report_mismatch("pair_end", want.pair_end, out_if.pair_end);
          if (out_if.value_mode !== want.value_mode)
            report_mismatch("value_mode", want.value_mode, out_if.value_mode);
          if (out_if.nest_depth !== want.nest_depth)
            report_mismatch("nest_depth", want.nest_depth, out_if.nest_depth);
        end
      end
      if ($urandom_range(0, 199) == 0) recv_calm = !recv_calm;
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = idle_length(recv_calm);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words outstanding", $time, expected_words.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int   target;
    int   klen;
    int   delim;
    int   depth;
    logic deep_done;
    in_if.valid = 1'b0;
    in_if.char_in = '0;
    out_if.ready = 1'b0;
    deep_done = 1'b0;

    foreach (directed_chars[i]) pending_chars.push_back(directed_chars[i]);
    target = pending_chars.size() + RANDOM_ITEMS;

    while (pending_chars.size() < target) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise and broken strings
        repeat ($urandom_range(1, 12)) pending_chars.push_back(CHAR_W'($urandom_range(0, 255)));
      end else if (!deep_done && pending_chars.size() > target / 3) begin
        // nesting past the counter maximum, then a few closes counting down
        deep_done = 1'b1;
        pending_chars.push_back("d");
        pending_chars.push_back(CH_LPAREN);
        repeat (LEVEL_MAX + 3) pending_chars.push_back(CH_LPAREN);
        repeat (5) pending_chars.push_back(CH_RPAREN);
        pending_chars.push_back("x");
        pending_chars.push_back(CH_NUL);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          repeat ($urandom_range(0, 2)) pending_chars.push_back(sep_char());
          klen = $urandom_range(0, 4);
          repeat (klen) pending_chars.push_back(key_char());
          delim = $urandom_range(0, 3);
          if (delim == 0) begin
            if ($urandom_range(0, 3) != 0) pending_chars.push_back(sep_char());
          end else begin
            pending_chars.push_back(delim == 1 ? CH_COLON : delim == 2 ? CH_EQUAL : CH_LPAREN);
            depth = 0;
            repeat ($urandom_range(0, 6)) begin
              case ($urandom_range(0, 9))
                0, 1: begin
                  pending_chars.push_back(CH_LPAREN);
                  depth++;
                end
                2, 3: begin
                  if (depth > 0) begin
                    pending_chars.push_back(CH_RPAREN);
                    depth--;
                  end else begin
                    pending_chars.push_back(value_char());
                  end
                end
                4: pending_chars.push_back(depth > 0 ? sep_char() : value_char());
                default: pending_chars.push_back(value_char());
              endcase
            end
            repeat (depth) pending_chars.push_back(CH_RPAREN);
            if ($urandom_range(0, 5) != 0)
              pending_chars.push_back(delim == 3 ? CH_RPAREN : sep_char());
          end
        end
        pending_chars.push_back(CH_NUL);
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_chars.size() != 0 || in_if.valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/kvpt_pkg.sv
rtl/kvpt_in_if.sv
rtl/kvpt_out_if.sv
rtl/kvpt_classify.sv
rtl/key_value_pair_tokenizer_core.sv
tb/key_value_pair_tokenizer_core_test.sv
